// ----- design/opa_pkg.sv -----
// Package for the outer-product accumulate tile: types, constants, float helpers.
`timescale 1ns / 1ps
package opa_pkg;

   localparam int TileDim = 4;
   localparam int Cells = TileDim * TileDim;
   localparam logic [31:0] ScaleReset = 32'h3F80_0000;
   localparam logic [31:0] QNaN = 32'h7FC0_0000;

   typedef struct packed {
      logic [31:0] a_row0;
      logic [31:0] a_row1;
      logic [31:0] a_row2;
      logic [31:0] a_row3;
      logic [31:0] b_col0;
      logic [31:0] b_col1;
      logic [31:0] b_col2;
      logic [31:0] b_col3;
      logic        last_slice;
   } req_type;

   typedef struct packed {
      logic [1:0]  tile_row;
      logic [1:0]  tile_col;
      logic [31:0] product_value;
      logic        final_element;
   } rsp_type;

   // Work carried from cell to cell: one multiply-add operand set.
   typedef struct packed {
      logic        vld;
      logic [31:0] a;
      logic [31:0] b;
      logic        last;
   } hop_type;

   // Unpacked operand: class flags, sign, unbiased exponent, 24-bit significand.
   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        zero;
      logic        sgn;
      logic signed [9:0] exp;
      logic [23:0] man;
   } fop_type;

   function automatic fop_type unpack(input logic [31:0] f);
      fop_type o;
      o.sgn  = f[31];
      o.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 0);
      o.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 0);
      o.zero = (f[30:0] == 0);
      if (f[30:23] == 0) begin
         o.exp = -10'sd126;
         o.man = {1'b0, f[22:0]};
      end else begin
         o.exp = $signed({2'b00, f[30:23]}) - 10'sd127;
         o.man = {1'b1, f[22:0]};
      end
      return o;
   endfunction

   // Count leading zeros of a 76-bit word.
   function automatic logic [6:0] clz76(input logic [75:0] v);
      logic [6:0] n;
      logic found;
      n = 7'd76;
      found = 1'b0;
      for (int i = 75; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 7'(75 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // Round a magnitude m (value = m * 2^(e - 75)) with sticky, to single.
   function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                              input logic [75:0] m, input logic stk);
      logic [6:0] lz;
      logic [75:0] nm;
      logic signed [11:0] ex;
      logic [6:0] sh;
      logic [75:0] dm;
      logic st;
      logic [24:0] q;
      logic g, rs;
      logic [8:0] be;
      if (m == 0) return {sgn, 31'd0};
      lz = clz76(m);
      nm = m << lz;
      ex = e - 12'(lz);
      // ex is the exponent of the leading bit
      st = stk;
      if (ex < -12'sd126) begin
         sh = (-12'sd126 - ex > 12'sd60) ? 7'd60 : 7'(-12'sd126 - ex);
         dm = nm >> sh;
         st = st | ((nm & ((76'd1 << sh) - 76'd1)) != 0);
         ex = -12'sd126;
      end else begin
         dm = nm;
      end
      q  = {1'b0, dm[75:52]};
      g  = dm[51];
      rs = (dm[50:0] != 0) | st;
      if (g && (rs || q[0])) q = q + 25'd1;
      if (q[24]) begin
         q = q >> 1;
         ex = ex + 12'sd1;
      end
      if (ex > 12'sd127) return {sgn, 8'hFF, 23'd0};
      if (!q[23]) return {sgn, 8'd0, q[22:0]};
      be = 9'(ex + 12'sd127);
      return {sgn, be[7:0], q[22:0]};
   endfunction

endpackage

// ----- design/opa_mul.sv -----
// Scale unit: rounds alpha times one accumulator, two register stages.
`timescale 1ns / 1ps
module opa_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_vld,
   input  logic [31:0] x,
   input  logic [31:0] y,
   input  logic [3:0]  in_idx,
   output logic        out_vld,
   output logic [3:0]  out_idx,
   output logic [31:0] out_val
);
   import opa_pkg::*;

   fop_type xa_ff, ya_ff;
   logic [47:0] prod_ff;
   logic vld1_ff, vld2_ff;
   logic [3:0] idx1_ff, idx2_ff;
   logic [31:0] res_ff;
   logic [31:0] res_in;
   fop_type xu, yu;

   assign xu = unpack(x);
   assign yu = unpack(y);

   // Stage one: multiply significands.
   always_ff @(posedge clock) begin
      if (reset) vld1_ff <= 1'b0;
      else vld1_ff <= in_vld;
      xa_ff   <= xu;
      ya_ff   <= yu;
      idx1_ff <= in_idx;
      prod_ff <= xu.man * yu.man;
   end

   // Stage two: handle specials and round.
   always_comb begin
      logic s;
      logic signed [11:0] e;
      s = xa_ff.sgn ^ ya_ff.sgn;
      e = 12'(xa_ff.exp) + 12'(ya_ff.exp) + 12'sd1;
      if (xa_ff.nan || ya_ff.nan || (xa_ff.inf && ya_ff.zero) || (ya_ff.inf && xa_ff.zero))
         res_in = QNaN;
      else if (xa_ff.inf || ya_ff.inf)
         res_in = {s, 8'hFF, 23'd0};
      else
         res_in = round_pack(s, e, {prod_ff, 28'd0}, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) vld2_ff <= 1'b0;
      else vld2_ff <= vld1_ff;
      idx2_ff <= idx1_ff;
      res_ff  <= res_in;
   end

   assign out_vld = vld2_ff;
   assign out_idx = idx2_ff;
   assign out_val = res_ff;
endmodule

// ----- design/opa_cell.sv -----
// One accumulator cell: fused multiply-add in three stages, passes operands on.
`timescale 1ns / 1ps
module opa_cell (
   input  logic        clock,
   input  logic        reset,
   input  opa_pkg::hop_type hop_i,
   input  logic        clr,
   output opa_pkg::hop_type hop_o,
   output logic [31:0] acc
);
   import opa_pkg::*;

   logic [31:0] acc_ff, acc_in;
   hop_type hop_ff;
   fop_type pa_ff, pb_ff;
   logic [47:0] prod_ff;
   logic vld1_ff, vld2_ff;
   logic spec_ff, spec_in;
   logic [31:0] sval_ff, sval_in;
   logic [75:0] sum_ff, sum_in;
   logic stk_ff, stk_in;
   logic rs_ff, rs_in;
   logic signed [11:0] eh_ff, eh_in;
   fop_type au, bu;
   fop_type cu;

   assign au = unpack(hop_i.a);
   assign bu = unpack(hop_i.b);
   assign cu = unpack(acc_ff);

   // Stage one: product of significands; pass operands to the neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         hop_ff.vld <= 1'b0;
      end else begin
         vld1_ff <= hop_i.vld;
         hop_ff.vld <= hop_i.vld;
      end
      hop_ff.a    <= hop_i.a;
      hop_ff.b    <= hop_i.b;
      hop_ff.last <= hop_i.last;
      pa_ff   <= au;
      pb_ff   <= bu;
      prod_ff <= au.man * bu.man;
   end

   // Stage two: resolve specials, align and add product and accumulator exactly.
   always_comb begin
      logic ps, pzero;
      logic signed [11:0] pe, ce;
      logic [75:0] pm, cm, lo;
      logic [7:0] d;
      logic [76:0] sum;
      ps = pa_ff.sgn ^ pb_ff.sgn;
      pzero = pa_ff.zero || pb_ff.zero;
      // Both as m * 2^(e-75) with leading room; product of 48 bits.
      pm = {2'b00, prod_ff, 26'd0};
      pe = 12'(pa_ff.exp) + 12'(pb_ff.exp) + 12'sd3;
      cm = {2'b00, cu.man, 50'd0};
      ce = 12'(cu.exp) + 12'sd2;
      lo = '0;
      d = '0;
      sum = '0;
      spec_in = 1'b1;
      sval_in = acc_ff;
      sum_in = '0;
      stk_in = 1'b0;
      rs_in = 1'b0;
      eh_in = '0;
      if (pa_ff.nan || pb_ff.nan || cu.nan ||
          (pa_ff.inf && pb_ff.zero) || (pb_ff.inf && pa_ff.zero) ||
          ((pa_ff.inf || pb_ff.inf) && cu.inf && (ps != cu.sgn)))
         sval_in = QNaN;
      else if (pa_ff.inf || pb_ff.inf)
         sval_in = {ps, 8'hFF, 23'd0};
      else if (cu.inf)
         sval_in = acc_ff;
      else if (pzero && cu.zero)
         sval_in = {ps & cu.sgn, 31'd0};
      else if (pzero)
         sval_in = acc_ff;
      else begin
         spec_in = 1'b0;
         // Align smaller exponent to larger
         if (pe >= ce) begin
            eh_in = pe;
            d = (pe - ce > 12'sd80) ? 8'd80 : 8'(pe - ce);
            lo = (d >= 8'd76) ? 76'd0 : (cm >> d);
            stk_in = (d >= 8'd76) ? (cm != 0) : ((cm & ((76'd1 << d) - 76'd1)) != 0);
            cm = lo;
         end else begin
            eh_in = ce;
            d = (ce - pe > 12'sd80) ? 8'd80 : 8'(ce - pe);
            lo = (d >= 8'd76) ? 76'd0 : (pm >> d);
            stk_in = (d >= 8'd76) ? (pm != 0) : ((pm & ((76'd1 << d) - 76'd1)) != 0);
            pm = lo;
         end
         // Borrow one from the difference when the subtracted term lost bits
         if (ps == cu.sgn) begin
            sum = {1'b0, pm} + {1'b0, cm};
            rs_in = ps;
         end else if (pm >= cm) begin
            sum = {1'b0, pm} - {1'b0, cm} - {76'd0, stk_in && (pe >= ce)};
            rs_in = ps;
         end else begin
            sum = {1'b0, cm} - {1'b0, pm} - {76'd0, stk_in && (pe < ce)};
            rs_in = cu.sgn;
         end
         sum_in = sum[75:0];
      end
   end

   // Hold the exact sum for the rounding stage.
   always_ff @(posedge clock) begin
      if (reset) vld2_ff <= 1'b0;
      else vld2_ff <= vld1_ff;
      spec_ff <= spec_in;
      sval_ff <= sval_in;
      sum_ff  <= sum_in;
      stk_ff  <= stk_in;
      rs_ff   <= rs_in;
      eh_ff   <= eh_in;
   end

   // Stage three: normalize and round once.
   always_comb begin
      acc_in = acc_ff;
      if (vld2_ff) begin
         if (spec_ff)
            acc_in = sval_ff;
         else if (sum_ff == 0 && !stk_ff)
            acc_in = {1'b0, 31'd0};
         else
            acc_in = round_pack(rs_ff, eh_ff, sum_ff, stk_ff);
      end
   end

   // Hold the accumulator; clear after a drain capture.
   always_ff @(posedge clock) begin
      if (reset) acc_ff <= 32'd0;
      else if (clr) acc_ff <= 32'd0;
      else acc_ff <= acc_in;
   end

   assign hop_o = hop_ff;
   assign acc = acc_ff;
endmodule

// ----- design/outer_product_accumulate_tile_core.sv -----
// Top level of the 4x4 outer-product accumulate tile.
`timescale 1ns / 1ps
// A chain of sixteen accumulator cells, column-major. A slice is accepted only
// while the block is idle; a start token then steps one cell per cycle along
// the chain and each cell adds its product into its accumulator with a
// three-stage fused multiply-add. An item holds the input while the token
// crosses the chain and the last cell finishes. A slice marked last is then
// drained through a two-stage scale multiplier with one scale in flight, so
// results leave one at a time, and receiver stalls stretch the drain; the
// block goes back to idle to accept the next item once the drain is done or,
// for any other slice, once the chain has finished. The chain latency sets
// the rate: one item at a time.
module outer_product_accumulate_tile_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  opa_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output opa_pkg::rsp_type rsp_data,
   input  logic            csr_write,
   input  logic [31:0]     csr_wdata
);
   import opa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_WAIT  = 4'b1000
   } state_type;

   state_type st_ff, st_in;
   logic [31:0] scale_ff;
   req_type item_ff;
   logic [4:0] cnt_ff, cnt_in;
   logic [4:0] sent_ff;
   logic [31:0] snap_ff [Cells];
   logic snap_go;
   hop_type hop [Cells+1];
   logic [31:0] acc [Cells];
   logic m_vld;
   logic [3:0] m_idx;
   logic [31:0] m_val;
   rsp_type out_ff;
   logic out_vld_ff;
   logic issue;
   logic [4:0] issued_ff;
   logic fifo_room;

   // Scale register.
   always_ff @(posedge clock) begin
      if (reset) scale_ff <= ScaleReset;
      else if (csr_write) scale_ff <= csr_wdata;
   end

   assign req_stall = (st_ff != ST_IDLE);

   // Sequencer: start the token along the chain, let it settle, then drain a last slice or go idle.
   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      snap_go = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (req_valid) begin
            st_in = ST_RUN;
            cnt_in = 5'd0;
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(Cells + 2)) begin
               if (item_ff.last_slice) begin
                  st_in = ST_DRAIN;
                  snap_go = 1'b1;
               end else st_in = ST_IDLE;
            end
         end
         ST_DRAIN: if (issued_ff == 5'(Cells)) st_in = ST_WAIT;
         ST_WAIT: if (sent_ff == 5'(Cells)) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
      cnt_ff <= cnt_in;
      if (st_ff == ST_IDLE && req_valid) item_ff <= req_data;
   end

   // Each cell sees the same slice; row and column pick its operands.
   // The start token enters cell 0 and is handed on by each cell.
   genvar g;
   generate
      for (g = 0; g < Cells; g++) begin : g_cell
         hop_type hin;
         always_comb begin
            logic [31:0] av, bv;
            unique case (g % TileDim)
               0: av = item_ff.a_row0;
               1: av = item_ff.a_row1;
               2: av = item_ff.a_row2;
               default: av = item_ff.a_row3;
            endcase
            unique case (g / TileDim)
               0: bv = item_ff.b_col0;
               1: bv = item_ff.b_col1;
               2: bv = item_ff.b_col2;
               default: bv = item_ff.b_col3;
            endcase
            hin = hop[g];
            if (g == 0) hin.vld = (st_ff == ST_RUN) && (cnt_ff == 5'd0);
            hin.a = av;
            hin.b = bv;
         end
         opa_cell u_cell (
            .clock(clock), .reset(reset),
            .hop_i(hin), .clr(snap_go), .hop_o(hop[g+1]), .acc(acc[g])
         );
      end
   endgenerate
   assign hop[0] = '{vld: 1'b0, a: 32'd0, b: 32'd0, last: 1'b0};

   // Capture the finished tile for the drain.
   always_ff @(posedge clock) begin
      if (snap_go) for (int i = 0; i < Cells; i++) snap_ff[i] <= acc[i];
   end

   // Issue one scale at a time, once the previous result has been sent and the output has room.
   assign fifo_room = !out_vld_ff || !rsp_stall;
   assign issue = (st_ff == ST_DRAIN) && (issued_ff < 5'(Cells)) &&
                  ((issued_ff - sent_ff) == 5'd0) && fifo_room;

   always_ff @(posedge clock) begin
      if (reset || snap_go) issued_ff <= 5'd0;
      else if (issue) issued_ff <= issued_ff + 5'd1;
   end

   opa_mul u_mul (
      .clock(clock), .reset(reset), .in_vld(issue), .x(snap_ff[issued_ff[3:0]]),
      .y(scale_ff), .in_idx(issued_ff[3:0]), .out_vld(m_vld), .out_idx(m_idx),
      .out_val(m_val)
   );

   // Output register; one scale in flight so it always has room.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         sent_ff <= 5'd0;
      end else begin
         if (snap_go) sent_ff <= 5'd0;
         else if (out_vld_ff && !rsp_stall) sent_ff <= sent_ff + 5'd1;
         if (m_vld) out_vld_ff <= 1'b1;
         else if (!rsp_stall) out_vld_ff <= 1'b0;
      end
      if (m_vld) begin
         out_ff.tile_row <= m_idx[1:0];
         out_ff.tile_col <= m_idx[3:2];
         out_ff.product_value <= m_val;
         out_ff.final_element <= (m_idx == 4'(Cells - 1));
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data = out_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_drain_order: assert property (@(posedge clock) disable iff (reset)
      (issued_ff >= sent_ff)) else $error("more results sent than issued");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
endmodule
